>>> rtl/tscl_pkg.sv
// ----------------------------------------------------------------------------
// tscl_pkg: shared types and codes of the two-stack cursor list
// Action codes, status codes, field widths and the sequencer types.
// ----------------------------------------------------------------------------
package tscl_pkg;

    localparam int ACTION_W = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;

    localparam logic [ACTION_W-1:0] ACT_PUSH   = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_FWD    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_BACK   = 3'd3;

    localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_BLOCKED  = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_NOCURSOR = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD0,
        S_RD1,
        S_RD2,
        S_WR0,
        S_WR1,
        S_CUR_RD,
        S_CUR_CAP
    } t_state;

    // Work that a successful action leaves for the sequencer.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_PUSH,
        OP_INS,
        OP_FWD1,
        OP_FWD2,
        OP_BACK
    } t_op;

    typedef enum logic [1:0] {
        CUR_NONE,
        CUR_AHEAD,
        CUR_BEHIND
    } t_cur_sel;

endpackage

>>> rtl/tscl_ram.sv
// ----------------------------------------------------------------------------
// tscl_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module tscl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/two_stack_cursor_list.sv
// ----------------------------------------------------------------------------
// two_stack_cursor_list: cursor list kept as an ahead stack and a behind stack
// Each transfer in carries one action; each returns the cursor and a status.
// ----------------------------------------------------------------------------
// Each stack lives in its own RAM with one write and one registered read a
// cycle, and a small sequencer walks every action through reads, writes and
// a final read of the cursor element. A read or a rejected action goes straight
// to the cursor read; a push ahead first writes the ahead stack; a move back,
// a move forward or an insert first reads one top element, or two for a move
// forward from an empty behind stack, and then writes, with a second write for
// insert and for that move forward. The input is ready only in idle, so a new
// item is taken only once the last has left the sequencer. The result register
// lets the next item start while a result still waits to be taken; the
// sequencer only holds if a second result would overwrite the first.
// ----------------------------------------------------------------------------
module two_stack_cursor_list #(
    parameter int STACK_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [2:0]  s_tuser,   // [2:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] cursor_value
    output logic [2:0]  m_tuser    // [2:0] status
);

    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);

    tscl_pkg::t_state   r_state, n_state;
    tscl_pkg::t_op      r_op, w_op;
    tscl_pkg::t_cur_sel r_cur_sel;

    logic [CNT_W-1:0]  r_ac, r_bc;
    logic [tscl_pkg::VALUE_W-1:0]  r_val, r_d0, r_d1;
    logic [tscl_pkg::STATUS_W-1:0] r_status, w_status;
    logic [tscl_pkg::VALUE_W-1:0]  r_m_data;
    logic [tscl_pkg::STATUS_W-1:0] r_m_user;
    logic              r_m_valid;

    logic [CNT_W-1:0]  w_ac_m1, w_ac_m2, w_bc_m1;
    logic              w_accept, w_out_free;

    logic                         a_we, a_re, b_we, b_re;
    logic [ADDR_W-1:0]            a_waddr, a_raddr, b_waddr, b_raddr;
    logic [tscl_pkg::VALUE_W-1:0] a_wdata, b_wdata, a_rdata, b_rdata;

    assign w_ac_m1    = r_ac - CNT_W'(1);
    assign w_ac_m2    = r_ac - CNT_W'(2);
    assign w_bc_m1    = r_bc - CNT_W'(1);
    assign s_tready   = i_rst_n && (r_state == tscl_pkg::S_IDLE);
    assign w_accept   = s_tvalid && s_tready;
    assign w_out_free = !r_m_valid || m_tready;

    // Status and follow-up work of the offered action, from the counts alone.
    always_comb begin
        w_status = tscl_pkg::STAT_OK;
        w_op     = tscl_pkg::OP_NONE;
        if (s_tuser == tscl_pkg::ACT_PUSH) begin
            if (r_ac >= CNT_FULL) begin
                w_status = tscl_pkg::STAT_FULL;
            end else begin
                w_op = tscl_pkg::OP_PUSH;
            end
        end else if (r_ac == '0 && r_bc == '0) begin
            w_status = tscl_pkg::STAT_EMPTY;
        end else if (s_tuser == tscl_pkg::ACT_INSERT) begin
            if (r_bc == '0) begin
                w_status = tscl_pkg::STAT_NOCURSOR;
            end else if (r_bc >= CNT_FULL) begin
                w_status = tscl_pkg::STAT_FULL;
            end else begin
                w_op = tscl_pkg::OP_INS;
            end
        end else if (s_tuser == tscl_pkg::ACT_FWD) begin
            if (r_bc == '0) begin
                if (r_ac < CNT_W'(2)) begin
                    w_status = tscl_pkg::STAT_BLOCKED;
                end else begin
                    w_op = tscl_pkg::OP_FWD2;
                end
            end else if (r_ac == '0) begin
                w_status = tscl_pkg::STAT_BLOCKED;
            end else if (r_bc >= CNT_FULL) begin
                w_status = tscl_pkg::STAT_FULL;
            end else begin
                w_op = tscl_pkg::OP_FWD1;
            end
        end else if (s_tuser == tscl_pkg::ACT_BACK) begin
            if (r_bc <= CNT_W'(1)) begin
                w_status = tscl_pkg::STAT_BLOCKED;
            end else if (r_ac >= CNT_FULL) begin
                w_status = tscl_pkg::STAT_FULL;
            end else begin
                w_op = tscl_pkg::OP_BACK;
            end
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tscl_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (w_op == tscl_pkg::OP_NONE) begin
                        n_state = tscl_pkg::S_CUR_RD;
                    end else if (w_op == tscl_pkg::OP_PUSH) begin
                        n_state = tscl_pkg::S_WR0;
                    end else begin
                        n_state = tscl_pkg::S_RD0;
                    end
                end
            end
            tscl_pkg::S_RD0: n_state = tscl_pkg::S_RD1;
            tscl_pkg::S_RD1: begin
                n_state = (r_op == tscl_pkg::OP_FWD2) ? tscl_pkg::S_RD2 : tscl_pkg::S_WR0;
            end
            tscl_pkg::S_RD2: n_state = tscl_pkg::S_WR0;
            tscl_pkg::S_WR0: begin
                if (r_op == tscl_pkg::OP_INS || r_op == tscl_pkg::OP_FWD2) begin
                    n_state = tscl_pkg::S_WR1;
                end else begin
                    n_state = tscl_pkg::S_CUR_RD;
                end
            end
            tscl_pkg::S_WR1:    n_state = tscl_pkg::S_CUR_RD;
            tscl_pkg::S_CUR_RD: n_state = tscl_pkg::S_CUR_CAP;
            tscl_pkg::S_CUR_CAP: begin
                if (w_out_free) begin
                    n_state = tscl_pkg::S_IDLE;
                end
            end
            default: n_state = tscl_pkg::S_IDLE;
        endcase
    end

    // Memory controls of each state.
    always_comb begin
        a_we    = 1'b0;
        a_re    = 1'b0;
        b_we    = 1'b0;
        b_re    = 1'b0;
        a_waddr = r_ac[ADDR_W-1:0];
        a_raddr = w_ac_m1[ADDR_W-1:0];
        b_waddr = r_bc[ADDR_W-1:0];
        b_raddr = w_bc_m1[ADDR_W-1:0];
        a_wdata = r_d0;
        b_wdata = r_d0;
        unique case (r_state)
            tscl_pkg::S_RD0: begin
                if (r_op == tscl_pkg::OP_INS || r_op == tscl_pkg::OP_BACK) begin
                    b_re = 1'b1;
                end else begin
                    a_re = 1'b1;
                end
            end
            tscl_pkg::S_RD1: begin
                if (r_op == tscl_pkg::OP_FWD2) begin
                    a_re    = 1'b1;
                    a_raddr = w_ac_m2[ADDR_W-1:0];
                end
            end
            tscl_pkg::S_WR0: begin
                unique case (r_op)
                    tscl_pkg::OP_PUSH: begin
                        a_we    = 1'b1;
                        a_wdata = r_val;
                    end
                    tscl_pkg::OP_BACK: a_we = 1'b1;
                    tscl_pkg::OP_FWD2: begin
                        b_we    = 1'b1;
                        b_waddr = ADDR_W'(0);
                    end
                    tscl_pkg::OP_INS, tscl_pkg::OP_FWD1: b_we = 1'b1;
                    default: ;
                endcase
            end
            tscl_pkg::S_WR1: begin
                b_we = 1'b1;
                if (r_op == tscl_pkg::OP_FWD2) begin
                    b_waddr = ADDR_W'(1);
                    b_wdata = r_d1;
                end else begin
                    b_waddr = w_bc_m1[ADDR_W-1:0];
                    b_wdata = r_val;
                end
            end
            tscl_pkg::S_CUR_RD: begin
                if (r_bc != '0) begin
                    b_re = 1'b1;
                end else if (r_ac != '0) begin
                    a_re = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tscl_pkg::S_IDLE;
            r_op      <= tscl_pkg::OP_NONE;
            r_cur_sel <= tscl_pkg::CUR_NONE;
            r_ac      <= '0;
            r_bc      <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_op     <= w_op;
                r_status <= w_status;
                r_val    <= s_tdata;
            end
            if (r_state == tscl_pkg::S_RD1) begin
                r_d0 <= (r_op == tscl_pkg::OP_INS || r_op == tscl_pkg::OP_BACK)
                        ? b_rdata : a_rdata;
            end
            if (r_state == tscl_pkg::S_RD2) begin
                r_d1 <= a_rdata;
            end
            if (r_state == tscl_pkg::S_WR0) begin
                unique case (r_op)
                    tscl_pkg::OP_PUSH: r_ac <= r_ac + CNT_W'(1);
                    tscl_pkg::OP_FWD1: begin
                        r_ac <= w_ac_m1;
                        r_bc <= r_bc + CNT_W'(1);
                    end
                    tscl_pkg::OP_BACK: begin
                        r_ac <= r_ac + CNT_W'(1);
                        r_bc <= w_bc_m1;
                    end
                    default: ;
                endcase
            end
            if (r_state == tscl_pkg::S_WR1) begin
                if (r_op == tscl_pkg::OP_FWD2) begin
                    r_ac <= w_ac_m2;
                    r_bc <= CNT_W'(2);
                end else begin
                    r_bc <= r_bc + CNT_W'(1);
                end
            end
            if (r_state == tscl_pkg::S_CUR_RD) begin
                if (r_bc != '0) begin
                    r_cur_sel <= tscl_pkg::CUR_BEHIND;
                end else if (r_ac != '0) begin
                    r_cur_sel <= tscl_pkg::CUR_AHEAD;
                end else begin
                    r_cur_sel <= tscl_pkg::CUR_NONE;
                end
            end
            if (r_state == tscl_pkg::S_CUR_CAP && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Result register; the RAM read data holds while the sequencer waits.
    always_ff @(posedge i_clk) begin
        if (r_state == tscl_pkg::S_CUR_CAP && w_out_free) begin
            r_m_user <= r_status;
            unique case (r_cur_sel)
                tscl_pkg::CUR_BEHIND: r_m_data <= b_rdata;
                tscl_pkg::CUR_AHEAD:  r_m_data <= a_rdata;
                default:              r_m_data <= '0;
            endcase
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;
    assign m_tuser  = r_m_user;

    tscl_ram #(
        .WIDTH (tscl_pkg::VALUE_W),
        .DEPTH (STACK_DEPTH)
    ) u_ahead_ram (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (a_waddr),
        .i_wdata (a_wdata),
        .i_re    (a_re),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    tscl_ram #(
        .WIDTH (tscl_pkg::VALUE_W),
        .DEPTH (STACK_DEPTH)
    ) u_behind_ram (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (b_waddr),
        .i_wdata (b_wdata),
        .i_re    (b_re),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

endmodule
